// ----- rtl/core/swrr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_pkg
// Shared types and codes for the weighted round robin peer selector.
// ----------------------------------------------------------------------------
package swrr_pkg;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_REPORT = 2'd1,
        OP_SET    = 2'd2,
        OP_RETIRE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NONE    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    localparam logic [0:0] CFG_FAIL_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_FAIL_WINDOW = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREF,
        S_SCAN,
        S_FINISH,
        S_REPORT,
        S_PEN_DIV,
        S_SET,
        S_RS_DIV1,
        S_RS_MUL,
        S_RS_DIV2,
        S_RS_APPLY,
        S_OUT
    } t_state;

    // divider control between sequencer and divider unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

// ----- rtl/core/swrr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swrr_div import swrr_pkg::*; #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output t_div_ctl     o_ctl,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, n_q;
    logic [W-1:0]  r_r, n_r;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [W:0]    w_trial;

    // shift one bit in, subtract when it fits
    always_comb begin
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_r, r_q[W-1]} - {1'b0, r_d};
        if (r_busy) begin
            if (!w_trial[W]) begin
                n_r = w_trial[W-1:0];
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_r = {r_r[W-2:0], r_q[W-1]};
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1; r_done <= 1'b0; r_cnt <= CW'(W);
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_q <= i_num; r_r <= '0; r_d <= i_den;
        end else begin
            r_q <= n_q; r_r <= n_r;
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quo = r_q;
    assign o_rem = r_r;
endmodule

// ----- rtl/core/smooth_weighted_rr_with_breaker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_weighted_rr_with_breaker_core
// Peer table with smooth weighted round robin select and a circuit breaker.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// request | in        | i_valid/o_ready      | operation .. now
// result  | out       | o_valid/i_ready      | status, chosen_slot, chosen_tag
// Select runs a preference pass that stops at the first preferred slot and a
// full update pass over the slots through a single compare/add unit. Report
// may run the penalty division. Set_peer with rescale runs the shared divider
// four times. Reset clears the table at once. A stalled result holds the block
// until it is taken.
// ----------------------------------------------------------------------------
module smooth_weighted_rr_with_breaker_core import swrr_pkg::*; #(
    parameter int NUM_SLOTS   = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_peer_tag,
    input  logic [15:0] i_weight,
    input  logic [7:0]  i_cluster_id,
    input  logic [7:0]  i_zone_id,
    input  logic        i_keep_runtime,
    input  logic [15:0] i_exclude_mask,
    input  logic        i_success,
    input  logic [47:0] i_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_chosen_slot,
    output logic [31:0] o_chosen_tag
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CB = WEIGHT_BITS + 8;
    localparam int DW = 2 * WEIGHT_BITS + 8;
    localparam int WB = WEIGHT_BITS;
    localparam logic signed [CB-1:0] CMAX = CB'((64'd1 << (WB + 7)) - 64'd1);
    localparam logic [DW-1:0] CMAXU = DW'((64'd1 << (WB + 7)) - 64'd1);

    // slot table
    logic [WB-1:0]        r_base [NUM_SLOTS];
    logic [WB-1:0]        r_eff  [NUM_SLOTS];
    logic signed [CB-1:0] r_cur  [NUM_SLOTS];
    logic [7:0]           r_fail [NUM_SLOTS];
    logic [TIME_BITS-1:0] r_acc  [NUM_SLOTS];
    logic [TIME_BITS-1:0] r_chk  [NUM_SLOTS];
    logic [31:0]          r_ep   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_ret;
    logic [7:0]           r_cl   [NUM_SLOTS];
    logic [7:0]           r_zn   [NUM_SLOTS];
    logic [31:0]          r_epoch;
    logic [7:0]           r_flim;
    logic [31:0]          r_fwin;

    // captured request
    t_op                  r_op;
    logic [3:0]           r_slot;
    logic [31:0]          r_tag;
    logic [WB-1:0]        r_w;
    logic [7:0]           r_rcl, r_rzn;
    logic                 r_keep, r_succ;
    logic [15:0]          r_excl;
    logic [TIME_BITS-1:0] r_now;

    t_state r_state, n_state;
    logic [SW-1:0] r_idx;
    logic          r_has_pref, r_found;
    logic [SW-1:0] r_best;
    logic signed [CB-1:0] r_best_cur;
    logic signed [CB+SW:0] r_total;
    logic [1:0]    r_st;
    logic [3:0]    r_oslot;
    logic [31:0]   r_otag;
    logic          r_ov;
    logic          r_which;   // 0 rescale current, 1 rescale effective
    logic          r_neg;
    logic [DW-1:0] r_q, r_fq;

    // divider hookup
    logic          w_dstart;
    logic [DW-1:0] w_dnum, w_dden, w_quo, w_rem;
    t_div_ctl      w_dctl;

    swrr_div #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_ctl(w_dctl), .o_quo(w_quo), .o_rem(w_rem)
    );

    logic w_slot_ok;
    assign w_slot_ok = (32'(r_slot) < 32'(NUM_SLOTS));
    logic [SW-1:0] w_s;
    assign w_s = SW'(r_slot);

    // per-slot filter for the scan index
    logic w_usable, w_pref, w_past;
    always_comb begin
        w_past = (r_now > r_chk[r_idx]) &&
                 ((r_now - r_chk[r_idx]) > TIME_BITS'(r_fwin));
        w_usable = !r_ret[r_idx] && (r_rcl == 8'd0 || r_cl[r_idx] == r_rcl) &&
                   !(32'(r_idx) < 32'd16 && r_excl[4'(r_idx)]) &&
                   (r_flim == 8'd0 || r_fail[r_idx] < r_flim || w_past);
        w_pref = r_rcl == 8'd0 || r_rzn == 8'd0 || r_zn[r_idx] == 8'd0 ||
                 r_zn[r_idx] == r_rzn;
    end

    function automatic logic signed [CB-1:0] sat(input logic signed [CB+SW+1:0] x);
        if (x > (CB+SW+2)'(CMAX)) return CMAX;
        if (x < -(CB+SW+2)'(CMAX)) return -CMAX;
        return x[CB-1:0];
    endfunction

    logic signed [CB-1:0] w_cur_add;
    assign w_cur_add = sat((CB+SW+2)'(r_cur[r_idx]) + (CB+SW+2)'($signed({1'b0, r_eff[r_idx]})));
    logic w_last;
    assign w_last = (32'(r_idx) == 32'(NUM_SLOTS - 1));

    logic w_keep_ok;
    assign w_keep_ok = r_keep && !r_ret[w_s] && r_ep[w_s] != 32'd0 && r_base[w_s] != '0;
    logic [WB-1:0] w_wn;
    assign w_wn = (r_w == '0) ? WB'(1) : r_w;

    // magnitude of the value being rescaled
    logic signed [CB-1:0] w_src;
    assign w_src = r_which ? CB'($signed({1'b0, r_eff[w_s]})) : r_cur[w_s];
    logic [DW-1:0] w_mag;
    assign w_mag = w_src[CB-1] ? DW'(-w_src) : DW'(w_src);

    // remainder times new weight, fed to the second division
    logic [2*WB-1:0] w_frac;
    assign w_frac = w_rem[WB-1:0] * w_wn;

    // rounded, saturated rescale result
    logic [CB+WB-1:0] w_scaled;
    assign w_scaled = r_q[CB-1:0] * w_wn;
    logic [DW-1:0] w_fq_r, w_res;
    logic [DW:0]   w_sum;
    always_comb begin
        w_fq_r = r_fq + DW'(((w_rem << 1) >= DW'(r_base[w_s])) ? 1 : 0);
        w_sum = (DW+1)'(w_scaled) + (DW+1)'(w_fq_r);
        if (w_sum > (DW+1)'(CMAXU)) w_res = CMAXU;
        else w_res = w_sum[DW-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) begin
                case (t_op'(i_operation))
                    OP_SELECT: n_state = S_PREF;
                    OP_REPORT: n_state = S_REPORT;
                    default:   n_state = S_SET;
                endcase
            end
            S_PREF:    if (w_last || (w_usable && w_pref)) n_state = S_SCAN;
            S_SCAN:    if (w_last) n_state = S_FINISH;
            S_FINISH:  n_state = S_OUT;
            S_REPORT:  n_state = (w_slot_ok && r_ep[w_s] != 0 && r_ep[w_s] == r_tag &&
                                  !r_succ && !r_ret[w_s] && r_flim != 0) ? S_PEN_DIV : S_OUT;
            S_PEN_DIV: if (w_dctl.done) n_state = S_OUT;
            S_SET:     n_state = (r_op == OP_SET && w_slot_ok && w_keep_ok) ? S_RS_DIV1 : S_OUT;
            S_RS_DIV1: if (w_dctl.done) n_state = S_RS_MUL;
            S_RS_MUL:  n_state = S_RS_DIV2;
            S_RS_DIV2: if (w_dctl.done) n_state = S_RS_APPLY;
            S_RS_APPLY: n_state = r_which ? S_OUT : S_RS_DIV1;
            S_OUT:     if (r_ov && i_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // divider operands
    always_comb begin
        w_dstart = 1'b0; w_dnum = '0; w_dden = DW'(1);
        case (r_state)
            S_REPORT: begin
                w_dstart = (n_state == S_PEN_DIV);
                w_dnum = DW'(r_base[w_s]) + DW'(r_flim) - DW'(1);
                w_dden = DW'(r_flim);
            end
            S_SET: begin
                w_dstart = (n_state == S_RS_DIV1);
                w_dnum = w_mag;
                w_dden = DW'(r_base[w_s]);
            end
            S_RS_APPLY: begin
                w_dstart = !r_which;
                w_dnum = DW'(r_eff[w_s]);
                w_dden = DW'(r_base[w_s]);
            end
            S_RS_MUL: begin
                w_dstart = 1'b1;
                w_dnum = DW'(w_frac);
                w_dden = DW'(r_base[w_s]);
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_chosen_slot = r_oslot;
    assign o_chosen_tag = r_otag;

    logic [WB-1:0] w_pen;
    assign w_pen = (w_quo == '0) ? WB'(1) : ((w_quo > DW'(r_eff[w_s])) ? r_eff[w_s] : WB'(w_quo));
    logic [TIME_BITS-1:0] w_ft;
    assign w_ft = (r_now > r_chk[w_s]) ? r_now : r_chk[w_s];
    logic [31:0] w_nep;
    assign w_nep = (r_epoch == 32'hFFFF_FFFF) ? 32'd1 : r_epoch + 32'd1;
    logic signed [CB+SW+1:0] w_sub;
    assign w_sub = (CB+SW+2)'(r_cur[r_best]) - (CB+SW+2)'(r_total);

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_ret <= '1; r_epoch <= '0;
            r_flim <= 8'd1; r_fwin <= 32'd10000;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_base[k] <= '0; r_eff[k] <= '0; r_cur[k] <= '0; r_fail[k] <= '0;
                r_acc[k] <= '0; r_chk[k] <= '0; r_ep[k] <= '0; r_cl[k] <= '0;
                r_zn[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            // store config writes on a completed handshake
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FAIL_LIMIT) r_flim <= i_cfg_data[7:0];
                else r_fwin <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op <= t_op'(i_operation); r_slot <= i_slot; r_tag <= i_peer_tag;
                    r_w <= WB'(i_weight); r_rcl <= i_cluster_id; r_rzn <= i_zone_id;
                    r_keep <= i_keep_runtime; r_succ <= i_success; r_excl <= i_exclude_mask;
                    r_now <= TIME_BITS'(i_now); r_idx <= '0; r_has_pref <= 1'b0;
                    r_found <= 1'b0; r_total <= '0; r_which <= 1'b0;
                    r_st <= ST_DONE; r_oslot <= i_slot; r_otag <= '0;
                end
                S_PREF: begin
                    if (w_usable && w_pref) begin
                        r_has_pref <= 1'b1; r_idx <= '0;
                    end else r_idx <= w_last ? '0 : r_idx + 1'b1;
                end
                S_SCAN: begin
                    if (w_usable && (!r_has_pref || w_pref)) begin
                        r_cur[r_idx] <= w_cur_add;
                        r_total <= r_total + (CB+SW+1)'(r_eff[r_idx]);
                        if (r_eff[r_idx] < r_base[r_idx]) r_eff[r_idx] <= r_eff[r_idx] + 1'b1;
                        if (!r_found || w_cur_add > r_best_cur) begin
                            r_found <= 1'b1; r_best <= r_idx; r_best_cur <= w_cur_add;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_FINISH: begin
                    if (!r_found) r_st <= ST_NONE;
                    else begin
                        r_cur[r_best] <= sat(w_sub);
                        if (r_now > r_chk[r_best] &&
                            (r_now - r_chk[r_best]) > TIME_BITS'(r_fwin))
                            r_chk[r_best] <= r_now;
                        r_oslot <= 4'(r_best); r_otag <= r_ep[r_best];
                    end
                    r_ov <= 1'b1;
                end
                S_REPORT: begin
                    if (!w_slot_ok) r_st <= ST_IGNORED;
                    else begin
                        r_otag <= r_ep[w_s];
                        if (r_ep[w_s] == 0 || r_ep[w_s] != r_tag) r_st <= ST_IGNORED;
                        else if (r_succ) begin
                            if (!r_ret[w_s] && r_acc[w_s] < r_chk[w_s]) r_fail[w_s] <= '0;
                        end else if (!r_ret[w_s]) begin
                            if (r_fail[w_s] != 8'hFF) r_fail[w_s] <= r_fail[w_s] + 1'b1;
                            r_acc[w_s] <= w_ft; r_chk[w_s] <= w_ft;
                        end
                    end
                    if (n_state == S_OUT) r_ov <= 1'b1;
                end
                S_PEN_DIV: if (w_dctl.done) begin
                    r_eff[w_s] <= r_eff[w_s] - w_pen; r_ov <= 1'b1;
                end
                S_SET: begin
                    if (!w_slot_ok) r_st <= ST_NONE;
                    else if (r_op == OP_RETIRE) begin
                        r_ret[w_s] <= 1'b1; r_otag <= r_ep[w_s];
                    end else if (!w_keep_ok) begin
                        r_epoch <= w_nep; r_ep[w_s] <= w_nep; r_base[w_s] <= w_wn;
                        r_eff[w_s] <= w_wn; r_cur[w_s] <= '0; r_fail[w_s] <= '0;
                        r_acc[w_s] <= '0; r_chk[w_s] <= '0; r_ret[w_s] <= 1'b0;
                        r_cl[w_s] <= r_rcl; r_zn[w_s] <= r_rzn; r_otag <= w_nep;
                    end
                    if (n_state == S_OUT) r_ov <= 1'b1;
                end
                S_RS_DIV1: if (w_dctl.done) r_q <= w_quo;
                S_RS_MUL: r_neg <= w_src[CB-1];
                S_RS_DIV2: if (w_dctl.done) r_fq <= w_quo;
                S_RS_APPLY: begin
                    if (!r_which) begin
                        r_cur[w_s] <= sat(r_neg ? -(CB+SW+2)'(w_res) : (CB+SW+2)'(w_res));
                        r_which <= 1'b1;
                    end else begin
                        r_eff[w_s] <= (w_res > DW'(w_wn)) ? w_wn : WB'(w_res);
                        r_base[w_s] <= w_wn; r_cl[w_s] <= r_rcl; r_zn[w_s] <= r_rzn;
                        r_otag <= r_ep[w_s]; r_ov <= 1'b1;
                    end
                end
                S_OUT: if (i_ready) r_ov <= 1'b0;
                default: ;
            endcase
        end
    end

    // checks
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dctl.start |-> !w_dctl.busy) else $error("divider restarted while busy");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
endmodule
